// ----- src/assert_macros.svh -----
// shared assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- src/fdc_pkg.sv -----
package fdc_pkg;

  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CIN_W   = 18;
  localparam int unsigned C_W     = 17;
  localparam int unsigned COS_W   = FRAC_BITS + 1;
  localparam int unsigned REFL_W  = FRAC_BITS + 2;
  localparam int unsigned TRANS_W = FRAC_BITS + 3;

  // square root unit
  localparam int unsigned RAD_W    = 64;
  localparam int unsigned ROOT_W   = 33;
  localparam int unsigned SQ_STEPS = 32;

  // divider unit: overflow step, four integer steps, fraction and round steps
  localparam int unsigned NUM_W     = 50;
  localparam int unsigned DEN_W     = 50;
  localparam int unsigned INT_STEPS = 5;
  localparam int unsigned REM_W     = DEN_W + INT_STEPS;
  localparam int unsigned DIV_STEPS = INT_STEPS + FRAC_BITS + 1;
  localparam int unsigned QUO_W     = DIV_STEPS;
  localparam int unsigned RND_W     = QUO_W - 1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_TIR  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic [IDX_W-1:0] n1;
    logic [IDX_W-1:0] n2;
    logic [C_W-1:0]   c;
    logic [32:0]      a;
    logic [31:0]      n2sq;
    logic             zero;
    logic             tir;
  } side_t;

  typedef struct packed {
    logic zero;
    logic tir;
    logic dz_s;
    logic dz_p;
    logic neg_s;
    logic neg_p;
  } flags_t;

endpackage

// ----- src/fdc_sqrt.sv -----
module fdc_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [fdc_pkg::RAD_W-1:0]     rad_i,
  input  fdc_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [fdc_pkg::ROOT_W-1:0]    root_o,
  output fdc_pkg::side_t                side_o
);

  localparam int unsigned N  = fdc_pkg::SQ_STEPS;
  localparam int unsigned RW = fdc_pkg::RAD_W;
  localparam int unsigned OW = fdc_pkg::ROOT_W;

  logic [N-1:0]          vld_q;
  logic [RW-1:0]         x_q   [N];
  logic [RW-1:0]         res_q [N];
  fdc_pkg::side_t        side_q [N];

  // one result bit per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    logic [RW-1:0]  x_in, res_in, bit_c, trial, x_d, res_d;
    logic           vld_in;
    fdc_pkg::side_t side_in;

    if (i == 0) begin : g_first
      assign x_in    = rad_i;
      assign res_in  = '0;
      assign vld_in  = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign x_in    = x_q[i-1];
      assign res_in  = res_q[i-1];
      assign vld_in  = vld_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign bit_c = RW'(1) << (RW - 2 - 2 * i);
    assign trial = res_in + bit_c;

    always_comb begin
      if (x_in >= trial) begin
        x_d   = x_in - trial;
        res_d = (res_in >> 1) + bit_c;
      end else begin
        x_d   = x_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= x_d;
        res_q[i]  <= res_d;
        side_q[i] <= side_in;
      end
    end
  end

  // round to nearest on the leftover
  logic [OW-1:0]  root_d, root_q;
  logic           out_vld_q;
  fdc_pkg::side_t out_side_q;

  assign root_d = res_q[N-1][OW-1:0] + OW'(x_q[N-1] > res_q[N-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q     <= root_d;
      out_side_q <= side_q[N-1];
    end
  end

  assign valid_o = out_vld_q;
  assign root_o  = root_q;
  assign side_o  = out_side_q;

endmodule

// ----- src/fdc_div.sv -----
module fdc_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [fdc_pkg::NUM_W-1:0]  num_i,
  input  logic [fdc_pkg::DEN_W-1:0]  den_i,
  output logic [fdc_pkg::QUO_W-1:0]  quo_o
);

  localparam int unsigned N  = fdc_pkg::DIV_STEPS;
  localparam int unsigned IS = fdc_pkg::INT_STEPS;
  localparam int unsigned RW = fdc_pkg::REM_W;
  localparam int unsigned DW = fdc_pkg::DEN_W;

  logic [RW-1:0] rem_q [N-1];
  logic [DW-1:0] den_q [N-1];
  logic [N-1:0]  quo_q [N];

  // restoring division, one quotient bit per stage; first bit flags overflow
  for (genvar j = 0; j < N; j++) begin : g_step
    logic [RW-1:0] rem_in, rem_cur, dsh, rem_d;
    logic [DW-1:0] den_in;
    logic [N-1:0]  quo_in;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = RW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    if (j < IS) begin : g_int
      assign rem_cur = rem_in;
      assign dsh     = RW'(den_in) << (IS - 1 - j);
    end else begin : g_frac
      assign rem_cur = rem_in << 1;
      assign dsh     = RW'(den_in);
    end

    assign ge    = rem_cur >= dsh;
    assign rem_d = ge ? rem_cur - dsh : rem_cur;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= {quo_in[N-2:0], ge};
      end
    end

    if (j < N - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= rem_d;
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[N-1];

endmodule

// ----- src/fresnel_dielectric_coefficients.sv -----
// Fresnel coefficients at a lossless dielectric boundary. Each request carries
// n1 and n2 (unsigned Q4.12) and the incidence cosine (signed Q1.16, clamped to
// 0..1); the result carries the refraction cosine, s and p reflection and
// transmission amplitudes and reflectances in Q16, rounded to nearest, plus a
// status (normal, total internal reflection, zero index). One request is taken
// every clock unless the output stalls; it passes through stages 1 to 3 of
// products, a 33-stage square root, stages p1 and p2 of numerator and denominator
// set-up, a (FRAC_BITS + 6)-stage divider and stages f1 and f2 of rounding and
// squaring. A stall at the output freezes the whole pipeline.
`include "assert_macros.svh"

module fresnel_dielectric_coefficients (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fdc_pkg::IDX_W-1:0]           index_in_i,
  input  logic [fdc_pkg::IDX_W-1:0]           index_out_i,
  input  logic signed [fdc_pkg::CIN_W-1:0]    cos_incidence_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fdc_pkg::COS_W-1:0]           cos_transmit_o,
  output logic signed [fdc_pkg::REFL_W-1:0]   refl_s_o,
  output logic signed [fdc_pkg::REFL_W-1:0]   refl_p_o,
  output logic [fdc_pkg::TRANS_W-1:0]         trans_s_o,
  output logic [fdc_pkg::TRANS_W-1:0]         trans_p_o,
  output logic [fdc_pkg::COS_W-1:0]           power_s_o,
  output logic [fdc_pkg::COS_W-1:0]           power_p_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned F   = fdc_pkg::FRAC_BITS;
  localparam int unsigned IW  = fdc_pkg::IDX_W;
  localparam int unsigned CW  = fdc_pkg::C_W;
  localparam int unsigned OW  = fdc_pkg::COS_W;
  localparam int unsigned RFW = fdc_pkg::REFL_W;
  localparam int unsigned TW  = fdc_pkg::TRANS_W;
  localparam int unsigned NW  = fdc_pkg::NUM_W;
  localparam int unsigned DW  = fdc_pkg::DEN_W;
  localparam int unsigned QW  = fdc_pkg::QUO_W;
  localparam int unsigned RNW = fdc_pkg::RND_W;
  localparam int unsigned BW  = fdc_pkg::ROOT_W;
  localparam int unsigned DS  = fdc_pkg::DIV_STEPS;

  localparam logic [CW-1:0]  C_ONE     = CW'(65536);
  localparam logic [32:0]    SQ_ONE    = 33'h1_0000_0000;
  localparam logic [RNW-1:0] RND_SAT   = {1'b1, {(RNW-1){1'b0}}};
  localparam logic [RNW-1:0] RND_ONE   = RNW'(1) << F;
  localparam logic [OW-1:0]  COS_ONE   = {1'b1, {F{1'b0}}};
  localparam logic [RFW-1:0] REFL_ONE  = RFW'(1) << F;
  localparam logic [TW-1:0]  TRANS_ONE = TW'(1) << F;
  localparam logic [2*OW:0]  HALF      = (2 * OW + 1)'(1) << (F - 1);

  function automatic logic [RNW-1:0] qround(input logic [QW-1:0] q);
    logic [RNW-1:0] v;
    if (q[QW-1]) begin
      v = RND_SAT;
    end else begin
      v = (q[RNW-1:0] >> 1) + RNW'(q[0]);
    end
    return v;
  endfunction

  logic en;
  logic out_vld_q;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // ---- stage 1: clamp and first products
  localparam int unsigned CIN_MSB = fdc_pkg::CIN_W - 1;

  logic [CW-1:0] c_d;
  logic          s1_vld_q, s1_zero_q;
  logic [IW-1:0] s1_n1_q, s1_n2_q;
  logic [CW-1:0] s1_c_q;
  logic [31:0]   s1_n1sq_q, s1_n2sq_q;
  logic [32:0]   s1_csq_q, s1_a_q;

  always_comb begin
    if (cos_incidence_i[CIN_MSB]) begin
      c_d = '0;
    end else if (cos_incidence_i[CW-1:0] > C_ONE) begin
      c_d = C_ONE;
    end else begin
      c_d = cos_incidence_i[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_n1_q   <= index_in_i;
      s1_n2_q   <= index_out_i;
      s1_c_q    <= c_d;
      s1_zero_q <= (index_in_i == '0) || (index_out_i == '0);
      s1_n1sq_q <= 32'(index_in_i) * 32'(index_in_i);
      s1_n2sq_q <= 32'(index_out_i) * 32'(index_out_i);
      s1_csq_q  <= 33'(c_d) * 33'(c_d);
      s1_a_q    <= 33'(index_in_i) * 33'(c_d);
    end
  end

  // ---- stage 2: n1^2 sin^2
  logic [32:0]   k_d;
  logic          s2_vld_q, s2_zero_q;
  logic [IW-1:0] s2_n1_q, s2_n2_q;
  logic [CW-1:0] s2_c_q;
  logic [32:0]   s2_a_q;
  logic [31:0]   s2_n2sq_q;
  logic [63:0]   s2_lhs_q;

  assign k_d = SQ_ONE - s1_csq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_n1_q   <= s1_n1_q;
      s2_n2_q   <= s1_n2_q;
      s2_c_q    <= s1_c_q;
      s2_a_q    <= s1_a_q;
      s2_n2sq_q <= s1_n2sq_q;
      s2_zero_q <= s1_zero_q;
      s2_lhs_q  <= 64'(s1_n1sq_q) * 64'(k_d);
    end
  end

  // ---- stage 3: critical-angle test and radicand
  logic [63:0]    p_d;
  logic           s3_vld_q;
  logic [63:0]    s3_rad_q;
  fdc_pkg::side_t s3_side_q;

  assign p_d = {s2_n2sq_q, 32'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_rad_q       <= p_d - s2_lhs_q;
      s3_side_q.n1   <= s2_n1_q;
      s3_side_q.n2   <= s2_n2_q;
      s3_side_q.c    <= s2_c_q;
      s3_side_q.a    <= s2_a_q;
      s3_side_q.n2sq <= s2_n2sq_q;
      s3_side_q.zero <= s2_zero_q;
      s3_side_q.tir  <= s2_lhs_q > p_d;
    end
  end

  // ---- n2 cos_t
  logic           sq_vld;
  logic [BW-1:0]  sq_root;
  fdc_pkg::side_t sq_side;

  fdc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .rad_i   (s3_rad_q),
    .side_i  (s3_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // ---- stage p1: p-polarisation products
  logic          p1_vld_q, p1_zero_q, p1_tir_q;
  logic [32:0]   p1_a_q, p1_b_q;
  logic [IW-1:0] p1_n2_q;
  logic [48:0]   p1_n2c_q, p1_n1b_q, p1_an2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_a_q    <= sq_side.a;
      p1_b_q    <= sq_root;
      p1_n2_q   <= sq_side.n2;
      p1_zero_q <= sq_side.zero;
      p1_tir_q  <= sq_side.tir;
      p1_n2c_q  <= 49'(sq_side.n2sq) * 49'(sq_side.c);
      p1_n1b_q  <= 49'(sq_side.n1) * 49'(sq_root);
      p1_an2_q  <= 49'(sq_side.a) * 49'(sq_side.n2);
    end
  end

  // ---- stage p2: numerators and denominators
  logic              p2_vld_q;
  fdc_pkg::flags_t   p2_fl_q;
  logic [NW-1:0]     p2_num_c_q, p2_num_rs_q, p2_num_ts_q, p2_num_rp_q, p2_num_tp_q;
  logic [DW-1:0]     p2_den_c_q, p2_den_s_q, p2_den_p_q;
  logic [DW-1:0]     den_s_d, den_p_d;

  assign den_s_d = DW'(p1_a_q) + DW'(p1_b_q);
  assign den_p_d = DW'(p1_n2c_q) + DW'(p1_n1b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_num_c_q    <= NW'(p1_b_q);
      p2_den_c_q    <= DW'({p1_n2_q, 16'd0});
      p2_num_rs_q   <= (p1_a_q >= p1_b_q) ? NW'(p1_a_q - p1_b_q) : NW'(p1_b_q - p1_a_q);
      p2_num_ts_q   <= NW'({p1_a_q, 1'b0});
      p2_den_s_q    <= den_s_d;
      p2_num_rp_q   <= (p1_n2c_q >= p1_n1b_q) ? NW'(p1_n2c_q - p1_n1b_q)
                                              : NW'(p1_n1b_q - p1_n2c_q);
      p2_num_tp_q   <= NW'({p1_an2_q, 1'b0});
      p2_den_p_q    <= den_p_d;
      p2_fl_q.zero  <= p1_zero_q;
      p2_fl_q.tir   <= p1_tir_q;
      p2_fl_q.dz_s  <= den_s_d == '0;
      p2_fl_q.dz_p  <= den_p_d == '0;
      p2_fl_q.neg_s <= p1_a_q < p1_b_q;
      p2_fl_q.neg_p <= p1_n2c_q < p1_n1b_q;
    end
  end

  // ---- dividers
  logic [QW-1:0] q_c, q_rs, q_ts, q_rp, q_tp;

  fdc_div u_div_cos (.clk_i(clk_i), .en_i(en), .num_i(p2_num_c_q),
                     .den_i(p2_den_c_q), .quo_o(q_c));
  fdc_div u_div_rs  (.clk_i(clk_i), .en_i(en), .num_i(p2_num_rs_q),
                     .den_i(p2_den_s_q), .quo_o(q_rs));
  fdc_div u_div_ts  (.clk_i(clk_i), .en_i(en), .num_i(p2_num_ts_q),
                     .den_i(p2_den_s_q), .quo_o(q_ts));
  fdc_div u_div_rp  (.clk_i(clk_i), .en_i(en), .num_i(p2_num_rp_q),
                     .den_i(p2_den_p_q), .quo_o(q_rp));
  fdc_div u_div_tp  (.clk_i(clk_i), .en_i(en), .num_i(p2_num_tp_q),
                     .den_i(p2_den_p_q), .quo_o(q_tp));

  // flags ride alongside the divider stages
  logic [DS-1:0]   dl_vld_q;
  fdc_pkg::flags_t dl_fl_q [DS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_vld_q <= '0;
    end else if (en) begin
      dl_vld_q <= {dl_vld_q[DS-2:0], p2_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_fl_q[0] <= p2_fl_q;
      for (int i = 1; i < DS; i++) begin
        dl_fl_q[i] <= dl_fl_q[i-1];
      end
    end
  end

  // ---- stage f1: rounding and clamps
  logic [RNW-1:0]  t_c, t_rs, t_ts, t_rp, t_tp;
  logic            f1_vld_q;
  fdc_pkg::flags_t f1_fl_q;
  logic [OW-1:0]   f1_cos_q, f1_ms_q, f1_mp_q;
  logic [RFW-1:0]  f1_rs_q, f1_rp_q;
  logic [TW-1:0]   f1_ts_q, f1_tp_q;

  assign t_c  = qround(q_c);
  assign t_rs = qround(q_rs);
  assign t_ts = qround(q_ts);
  assign t_rp = qround(q_rp);
  assign t_tp = qround(q_tp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= dl_vld_q[DS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_fl_q  <= dl_fl_q[DS-1];
      f1_cos_q <= (t_c > RND_ONE) ? COS_ONE : t_c[OW-1:0];
      f1_ms_q  <= t_rs[OW-1:0];
      f1_mp_q  <= t_rp[OW-1:0];
      f1_rs_q  <= dl_fl_q[DS-1].neg_s ? RFW'(0) - RFW'(t_rs[OW-1:0]) : RFW'(t_rs[OW-1:0]);
      f1_rp_q  <= dl_fl_q[DS-1].neg_p ? RFW'(0) - RFW'(t_rp[OW-1:0]) : RFW'(t_rp[OW-1:0]);
      f1_ts_q  <= (|t_ts[RNW-1:TW]) ? {TW{1'b1}} : t_ts[TW-1:0];
      f1_tp_q  <= (|t_tp[RNW-1:TW]) ? {TW{1'b1}} : t_tp[TW-1:0];
    end
  end

  // ---- stage f2: reflectances, special cases, output register
  logic [2*OW:0]    psq_s, psq_p;
  logic [OW-1:0]    cos_d, ps_d, pp_d;
  logic [RFW-1:0]   rs_d, rp_d;
  logic [TW-1:0]    ts_d, tp_d;
  fdc_pkg::status_e st_d;

  assign psq_s = (2 * OW + 1)'(f1_ms_q) * (2 * OW + 1)'(f1_ms_q) + HALF;
  assign psq_p = (2 * OW + 1)'(f1_mp_q) * (2 * OW + 1)'(f1_mp_q) + HALF;

  always_comb begin
    cos_d = f1_cos_q;
    rs_d  = f1_rs_q;
    rp_d  = f1_rp_q;
    ts_d  = f1_ts_q;
    tp_d  = f1_tp_q;
    ps_d  = psq_s[F +: OW];
    pp_d  = psq_p[F +: OW];
    st_d  = fdc_pkg::ST_OK;
    if (f1_fl_q.zero) begin
      cos_d = '0;
      rs_d  = '0;
      rp_d  = '0;
      ts_d  = '0;
      tp_d  = '0;
      ps_d  = '0;
      pp_d  = '0;
      st_d  = fdc_pkg::ST_ZERO;
    end else if (f1_fl_q.tir) begin
      cos_d = '0;
      rs_d  = REFL_ONE;
      rp_d  = REFL_ONE;
      ts_d  = '0;
      tp_d  = '0;
      ps_d  = COS_ONE;
      pp_d  = COS_ONE;
      st_d  = fdc_pkg::ST_TIR;
    end else begin
      // grazing incidence with matched indices
      if (f1_fl_q.dz_s) begin
        rs_d = '0;
        ps_d = '0;
        ts_d = TRANS_ONE;
      end
      if (f1_fl_q.dz_p) begin
        rp_d = '0;
        pp_d = '0;
        tp_d = TRANS_ONE;
      end
    end
  end

  logic [OW-1:0]    out_cos_q, out_ps_q, out_pp_q;
  logic [RFW-1:0]   out_rs_q, out_rp_q;
  logic [TW-1:0]    out_ts_q, out_tp_q;
  fdc_pkg::status_e out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_cos_q    <= cos_d;
      out_rs_q     <= rs_d;
      out_rp_q     <= rp_d;
      out_ts_q     <= ts_d;
      out_tp_q     <= tp_d;
      out_ps_q     <= ps_d;
      out_pp_q     <= pp_d;
      out_status_q <= st_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign cos_transmit_o = out_cos_q;
  assign refl_s_o       = out_rs_q;
  assign refl_p_o       = out_rp_q;
  assign trans_s_o      = out_ts_q;
  assign trans_p_o      = out_tp_q;
  assign power_s_o      = out_ps_q;
  assign power_p_o      = out_pp_q;
  assign status_o       = out_status_q;

  `ASSERT_IMP(a_zero_idx_clear, clk_i, rst_ni, out_vld_q && (out_status_q == fdc_pkg::ST_ZERO), (out_cos_q == '0) && (out_ts_q == '0) && (out_tp_q == '0) && (out_ps_q == '0))
  `ASSERT_IMP(a_tir_fields, clk_i, rst_ni, out_vld_q && (out_status_q == fdc_pkg::ST_TIR), (out_cos_q == '0) && (out_ps_q == COS_ONE) && (out_pp_q == COS_ONE))
  `ASSERT_IMP(a_cos_bounded, clk_i, rst_ni, out_vld_q, out_cos_q <= COS_ONE)
  `ASSERT_NXT(a_pipe_frozen, clk_i, rst_ni, !en, $stable(s3_vld_q) && $stable(p2_vld_q) && $stable(f1_vld_q))

endmodule

// ----- tb/tb_fresnel_dielectric_coefficients.sv -----
`timescale 1ns / 1ps

module tb_fresnel_dielectric_coefficients;

  localparam int unsigned FRAC_BITS  = fdc_pkg::FRAC_BITS;
  localparam int unsigned IDX_W      = fdc_pkg::IDX_W;
  localparam int unsigned CIN_W      = fdc_pkg::CIN_W;
  localparam int unsigned COS_W      = fdc_pkg::COS_W;
  localparam int unsigned REFL_W     = fdc_pkg::REFL_W;
  localparam int unsigned TRANS_W    = fdc_pkg::TRANS_W;
  localparam int unsigned LATENCY    = FRAC_BITS + 46;
  localparam int unsigned HANG_LIMIT = 4000;
  localparam int unsigned N_RANDOM   = 1030;
  localparam int unsigned QUIET_FROM = 880;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [COS_W-1:0]   cos_t;
    logic [REFL_W-1:0]  rs;
    logic [REFL_W-1:0]  rp;
    logic [TRANS_W-1:0] ts;
    logic [TRANS_W-1:0] tp;
    logic [COS_W-1:0]   ps;
    logic [COS_W-1:0]   pp;
    fdc_pkg::status_e   st;
  } coeffs_t;

  class fresnel_scoreboard;
    coeffs_t expected_q[$];
    int unsigned mismatches = 0;

    static function u64_t fix_div(u64_t num, u64_t den);
      u64_t q, r;
      q = num / den;
      r = num % den;
      if (q >= 16) return u64_t'(16) << FRAC_BITS;
      for (int i = 0; i < FRAC_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q + 1;
        end
      end
      r = r << 1;
      if (r >= den) q = q + 1;
      return q;
    endfunction

    static function u64_t root_nearest(u64_t x);
      u64_t res, bitv;
      res = 0;
      bitv = u64_t'(1) << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      if (x > res) res = res + 1;
      return res;
    endfunction

    static function u64_t sq_q(u64_t m);
      return (m * m + (u64_t'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    endfunction

    static function u64_t sat_trans(u64_t t);
      u64_t tmax;
      tmax = (u64_t'(8) << FRAC_BITS) - 1;
      return (t > tmax) ? tmax : t;
    endfunction

    static function coeffs_t fresnel(logic [IDX_W-1:0] n1_v, logic [IDX_W-1:0] n2_v,
                                     logic [CIN_W-1:0] cin);
      coeffs_t e;
      u64_t one, n1, n2, c, k, lhs, p, a, b, den, m, t, pos, neg;
      one = u64_t'(1) << FRAC_BITS;
      e = '0;
      e.st = fdc_pkg::ST_OK;
      n1 = n1_v;
      n2 = n2_v;
      if (n1 == 0 || n2 == 0) begin
        e.st = fdc_pkg::ST_ZERO;
        return e;
      end
      if (cin[CIN_W-1]) c = 0;
      else if (cin > 65536) c = 65536;
      else c = cin;
      k = (u64_t'(1) << 32) - c * c;
      lhs = n1 * n1 * k;
      p = (n2 * n2) << 32;
      if (lhs > p) begin
        e.rs = one;
        e.rp = one;
        e.ps = one;
        e.pp = one;
        e.st = fdc_pkg::ST_TIR;
        return e;
      end
      a = n1 * c;
      b = root_nearest(p - lhs);
      t = fix_div(b, n2 << 16);
      e.cos_t = (t > one) ? one : t;
      // s polarisation
      den = a + b;
      if (den == 0) begin
        e.ts = one;
      end else begin
        m = (a >= b) ? fix_div(a - b, den) : fix_div(b - a, den);
        e.rs = (a >= b) ? m : -m;
        e.ps = sq_q(m);
        e.ts = sat_trans(fix_div(2 * a, den));
      end
      // p polarisation, terms scaled by n2
      pos = n2 * n2 * c;
      neg = n1 * b;
      den = pos + neg;
      if (den == 0) begin
        e.tp = one;
      end else begin
        m = (pos >= neg) ? fix_div(pos - neg, den) : fix_div(neg - pos, den);
        e.rp = (pos >= neg) ? m : -m;
        e.pp = sq_q(m);
        e.tp = sat_trans(fix_div(2 * a * n2, den));
      end
      return e;
    endfunction

    function void note_request(logic [IDX_W-1:0] n1, logic [IDX_W-1:0] n2,
                               logic [CIN_W-1:0] cin);
      expected_q.push_back(fresnel(n1, n2, cin));
    endfunction

    function void check_result(coeffs_t got);
      coeffs_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [IDX_W-1:0] index_in_i = '0;
  logic [IDX_W-1:0] index_out_i = '0;
  logic signed [CIN_W-1:0] cos_incidence_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [COS_W-1:0] cos_transmit_o;
  logic signed [REFL_W-1:0] refl_s_o, refl_p_o;
  logic [TRANS_W-1:0] trans_s_o, trans_p_o;
  logic [COS_W-1:0] power_s_o, power_p_o;
  logic [1:0] status_o;

  fresnel_scoreboard sb = new();
  bit quiet = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;

  always #5 clk_i = ~clk_i;

  fresnel_dielectric_coefficients uut (.*);

  // drive one request, after an occasional idle gap, and hold it until taken
  task automatic send_request(logic [IDX_W-1:0] n1, logic [IDX_W-1:0] n2,
                              logic [CIN_W-1:0] cin);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    index_in_i <= n1;
    index_out_i <= n2;
    cos_incidence_i <= cin;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(n1, n2, cin);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 3))
      0: return IDX_W'($urandom);
      1: return IDX_W'($urandom_range(1, 16));
      default: return IDX_W'($urandom_range(3900, 10000));
    endcase
  endfunction

  function automatic logic [CIN_W-1:0] pick_cos();
    case ($urandom_range(0, 4))
      0: return CIN_W'($urandom);
      1: return CIN_W'($urandom_range(0, 200));
      default: return CIN_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // output side: random stall bursts, result check, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (out_valid_o && !out_stall_i)
        sb.check_result('{cos_transmit_o, refl_s_o, refl_p_o, trans_s_o, trans_p_o,
                          power_s_o, power_p_o, fdc_pkg::status_e'(status_o)});
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // zero index, clamp limits, total reflection, grazing with equal media
    send_request(16'd0, 16'd4096, 18'd30000);
    send_request(16'd4096, 16'd0, 18'd30000);
    send_request(16'd0, 16'd0, 18'd0);
    send_request(16'd4096, 16'd6144, 18'h20000);
    send_request(16'd4096, 16'd6144, 18'h3FFFF);
    send_request(16'd4096, 16'd6144, 18'd65536);
    send_request(16'd4096, 16'd6144, 18'd65537);
    send_request(16'd4096, 16'd6144, 18'h1FFFF);
    send_request(16'd6144, 16'd4096, 18'd0);
    send_request(16'd6144, 16'd4096, 18'd10000);
    send_request(16'd6144, 16'd4096, 18'd65536);
    send_request(16'd4096, 16'd4096, 18'd0);
    send_request(16'd4096, 16'd4096, 18'd65536);
    send_request(16'hFFFF, 16'hFFFF, 18'd0);
    send_request(16'hFFFF, 16'd1, 18'd65536);
    send_request(16'd1, 16'hFFFF, 18'd0);
    send_request(16'd1, 16'hFFFF, 18'd65536);
    send_request(16'hFFFF, 16'd1, 18'h1FFFF);
    send_request(16'd1, 16'd1, 18'd1);
    send_request(16'd5000, 16'd4096, 18'd36000);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        send_request(pick_index(), 16'd0, pick_cos());
      end else begin
        send_request(pick_index(), pick_index(), pick_cos());
      end
    end
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/fdc_pkg.sv
src/fdc_sqrt.sv
src/fdc_div.sv
src/fresnel_dielectric_coefficients.sv
tb/tb_fresnel_dielectric_coefficients.sv
